### rtl/cbts_pkg.sv
`timescale 1ns / 1ps
// Package for the CAN bit timing solver: result codes, controller states,
// command and status structs, and the quanta split function.
// No dependencies.
package cbts_pkg;

	localparam logic [31:0] CLOCK_RESET = 32'd84000000;
	localparam int unsigned TQ_MIN = 8;
	localparam int unsigned TQ_MAX = 25;
	localparam int unsigned SEG_MIN = 1;
	localparam int unsigned PROP_SEG_MAX = 8;
	localparam int unsigned PH1_SEG_MAX = 8;
	localparam int unsigned PH2_SEG_MAX = 8;
	localparam int unsigned SAMPLE_NUM = 64;
	localparam int unsigned SAMPLE_DEN = 73;
	localparam int unsigned SAMPLE_HALF = SAMPLE_DEN / 2;
	localparam int unsigned SAMPLE_SHIFT = 16;
	localparam int unsigned SAMPLE_RECIP = ((1 << SAMPLE_SHIFT) + SAMPLE_DEN - 1) / SAMPLE_DEN;
	localparam logic [7:0] PRESC_MAX = 8'd128;
	localparam int unsigned DIV_STEPS = 32;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_ZERO_RATE    = 2'd1,
		ST_NOT_MULTIPLE = 2'd2,
		ST_NO_FIT       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    step;
		logic    next;
		logic    finish;
		status_t code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic rate_zero;
		logic rem_zero;
		logic first;
		logic fit;
		logic last;
	} dp_sts_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] prop;
		logic [3:0] ph1;
		logic [3:0] ph2;
	} seg_t;

	function automatic seg_t split_quanta(input logic [4:0] q);
		seg_t        r;
		logic [4:0]  t;
		logic [10:0] p1w;
		logic [20:0] p1m;
		logic [4:0]  p1;
		logic [4:0]  pr;
		logic [4:0]  p2;
		r = '0;
		t = q - 5'd1;
		p1w = 11'({t, 6'b0}) + 11'(SAMPLE_HALF);
		// The scaled reciprocal of the divisor is exact over the range of p1w.
		p1m = 21'(p1w) * 21'(SAMPLE_RECIP);
		p1 = 5'(p1m >> SAMPLE_SHIFT);
		pr = 5'd0;
		if (p1 > 5'(PH1_SEG_MAX)) begin
			pr = p1 - 5'(PH1_SEG_MAX);
			p1 = 5'(PH1_SEG_MAX);
		end
		p2 = t - (pr + p1);
		r.ok = (q >= 5'(TQ_MIN)) && (q <= 5'(TQ_MAX)) &&
			(pr >= 5'(SEG_MIN)) && (pr <= 5'(PROP_SEG_MAX)) &&
			(p1 >= 5'(SEG_MIN)) && (p1 <= 5'(PH1_SEG_MAX)) &&
			(p2 >= 5'(SEG_MIN)) && (p2 <= 5'(PH2_SEG_MAX));
		r.prop = pr[3:0];
		r.ph1 = p1[3:0];
		r.ph2 = p2[3:0];
		return r;
	endfunction

endpackage

### rtl/cbts_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the CAN bit timing solver.
// Depends on cbts_pkg; drives the datapath in cbts_dp by commands.
module cbts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cbts_pkg::dp_sts_t   sts,
	output cbts_pkg::ctrl_cmd_t cmd
);
	import cbts_pkg::*;

	state_t  state_q, state_d;
	status_t code_q;
	status_t check_code;
	logic    check_done;
	logic    out_valid_q;
	logic    slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		check_done = 1'b1;
		check_code = ST_OK;
		if (sts.rate_zero) begin
			check_code = ST_ZERO_RATE;
		end else if (sts.first && !sts.rem_zero) begin
			check_code = ST_NOT_MULTIPLE;
		end else if (sts.fit) begin
			check_code = ST_OK;
		end else if (sts.last) begin
			check_code = ST_NO_FIT;
		end else begin
			check_done = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = check_done ? S_WAIT : S_DIV;
			end
			S_WAIT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DIV: begin
				cmd.step = 1'b1;
			end
			S_CHECK: begin
				cmd.next = !check_done;
			end
			S_WAIT: begin
				cmd.finish = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) code_q <= check_code;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/cbts_dp.sv
`timescale 1ns / 1ps
// Datapath of the CAN bit timing solver: clock register, bit-serial divider,
// prescaler search registers and result registers. Depends on cbts_pkg.
module cbts_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	input  logic [31:0]         bitrate_bps,
	input  cbts_pkg::ctrl_cmd_t cmd,
	output cbts_pkg::dp_sts_t   sts,
	output logic [1:0]          status,
	output logic [7:0]          prescaler,
	output logic [3:0]          propagation_tq,
	output logic [3:0]          phase_one_tq,
	output logic [3:0]          phase_two_tq,
	output logic [22:0]         timing_word
);
	import cbts_pkg::*;

	logic [31:0] clock_q;
	logic [31:0] rate_q;
	logic [39:0] div_q;
	logic [7:0]  brp_q;
	logic [39:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;

	logic [40:0] shifted;
	logic [41:0] diff;
	logic [40:0] next_div;
	logic        quo_in_range;
	seg_t        seg;
	logic [6:0]  brp_m1;

	logic [1:0]  status_q;
	logic [7:0]  prescaler_q;
	logic [3:0]  prop_q;
	logic [3:0]  ph1_q;
	logic [3:0]  ph2_q;
	logic [22:0] word_q;

	assign shifted = {rem_q, quo_q[31]};
	assign diff = {1'b0, shifted} - {2'b0, div_q};
	assign next_div = {1'b0, div_q} + {9'b0, rate_q};
	assign quo_in_range = (quo_q >= 32'(TQ_MIN)) && (quo_q <= 32'(TQ_MAX));
	assign seg = split_quanta(quo_q[4:0]);
	assign brp_m1 = 7'(brp_q - 8'd1);

	assign sts.div_done = (cnt_q == 5'(DIV_STEPS - 1));
	assign sts.rate_zero = (rate_q == 32'd0);
	assign sts.rem_zero = (rem_q == 40'd0);
	assign sts.first = (brp_q == 8'd1);
	assign sts.fit = (rem_q == 40'd0) && quo_in_range && seg.ok;
	assign sts.last = (brp_q == PRESC_MAX) || (next_div > {9'b0, clock_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg_wr_en) begin
			clock_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rate_q <= bitrate_bps;
			div_q <= {8'b0, bitrate_bps};
			brp_q <= 8'd1;
			rem_q <= '0;
			quo_q <= clock_q;
			cnt_q <= '0;
		end else if (cmd.next) begin
			div_q <= next_div[39:0];
			brp_q <= brp_q + 8'd1;
			rem_q <= '0;
			quo_q <= clock_q;
			cnt_q <= '0;
		end else if (cmd.step) begin
			if (!diff[41]) begin
				rem_q <= diff[39:0];
			end else begin
				rem_q <= shifted[39:0];
			end
			quo_q <= {quo_q[30:0], !diff[41]};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.code;
			if (cmd.code == ST_OK) begin
				prescaler_q <= brp_q;
				prop_q <= seg.prop;
				ph1_q <= seg.ph1;
				ph2_q <= seg.ph2;
				word_q <= {brp_m1, 5'b0, 3'(seg.prop - 4'd1), 1'b0,
					3'(seg.ph1 - 4'd1), 1'b0, 3'(seg.ph2 - 4'd1)};
			end else begin
				prescaler_q <= '0;
				prop_q <= '0;
				ph1_q <= '0;
				ph2_q <= '0;
				word_q <= '0;
			end
		end
	end

	assign status = status_q;
	assign prescaler = prescaler_q;
	assign propagation_tq = prop_q;
	assign phase_one_tq = ph1_q;
	assign phase_two_tq = ph2_q;
	assign timing_word = word_q;

endmodule

### rtl/can_bit_timing_solver_unit.sv
`timescale 1ns / 1ps
// Top level of the CAN bit timing solver: controller plus datapath.
// Depends on cbts_pkg, cbts_ctrl and cbts_dp.
//
// Channel   Handshake               Payload
// input     in_valid / in_ready     bitrate_bps
// output    out_valid / out_ready   status, prescaler, propagation_tq,
//                                   phase_one_tq, phase_two_tq, timing_word
// config    cfg_wr_en               cfg_wr_data (clock_hz)
//
// Each prescaler trial is one 32-bit shift-subtract division plus one check
// state; a transaction runs at most 128 prescaler trials.
// The search stops early once the next prescaler times bitrate exceeds the clock.
// Reset loads clock_hz with 84000000 and leaves the block idle.
// A new transaction is taken while a finished result waits; the next result
// stalls in the controller until the output register is free.
module can_bit_timing_solver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] bitrate_bps,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  prescaler,
	output logic [3:0]  propagation_tq,
	output logic [3:0]  phase_one_tq,
	output logic [3:0]  phase_two_tq,
	output logic [22:0] timing_word
);
	import cbts_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	cbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.bitrate_bps    (bitrate_bps),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.prescaler      (prescaler),
		.propagation_tq (propagation_tq),
		.phase_one_tq   (phase_one_tq),
		.phase_two_tq   (phase_two_tq),
		.timing_word    (timing_word)
	);

`ifndef NO_ASSERTIONS
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(prescaler == 8'd0) && (timing_word == 23'd0) &&
			(propagation_tq == 4'd0) && (phase_two_tq == 4'd0))
		else $error("Error result carries nonzero timing fields.");

	a_ok_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |->
			(prescaler >= 8'd1) && (prescaler <= 8'd128) &&
			(propagation_tq >= 4'd1) && (propagation_tq <= 4'd8) &&
			(phase_one_tq >= 4'd1) && (phase_one_tq <= 4'd8) &&
			(phase_two_tq >= 4'd1) && (phase_two_tq <= 4'd8))
		else $error("Successful result has a segment out of range.");

	a_word_presc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |->
			(timing_word[22:16] == 7'(prescaler - 8'd1)))
		else $error("Timing word does not match the prescaler.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input ready stayed high after a transaction.");
`endif

endmodule
